FILE: hw/rtl/tiam_pkg.sv
// Package: shared types, constants and bit helpers for the ignore-mask analyser.
`timescale 1ns / 1ps

package tiam_pkg;

	localparam int MAX_INPUTS  = 12;
	localparam int MAX_OUTPUTS = 10;
	localparam int ADDR_W      = 12;
	localparam int VAL_W       = 10;
	localparam int DEPTH       = 4096;
	localparam int PACK_W      = 22;
	localparam int CNT_W       = 4;

	localparam logic [1:0] REQ_LOAD    = 2'd0;
	localparam logic [1:0] REQ_ANALYZE = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;

	localparam logic [0:0] CFG_NUM_INPUTS  = 1'b0;
	localparam logic [0:0] CFG_NUM_OUTPUTS = 1'b1;

	typedef struct packed {
		logic             written;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic [ADDR_W-1:0] first_unset_index;
		logic              table_incomplete;
		logic [PACK_W-1:0] packed_word;
	} result_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_RD,
		S_CLR_RD,
		S_CLR_CHK,
		S_VIS_RD,
		S_VIS_CHK,
		S_CAND_RD,
		S_CAND_CHK,
		S_SUB_INIT,
		S_SUB_RD,
		S_SUB_CHK,
		S_BAD_RD,
		S_BAD_CHK,
		S_SUB_WR,
		S_MARK
	} state_t;

	function automatic logic [CNT_W-1:0] popcount(input logic [ADDR_W-1:0] v);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < ADDR_W; i++) begin
			n = n + CNT_W'(v[i]);
		end
		return n;
	endfunction

	// Places the low bits of code at the set positions of mask, lowest first.
	// Each position looks up its own rank, so the positions are independent.
	function automatic logic [ADDR_W-1:0] deposit(input logic [ADDR_W-1:0] code,
			input logic [ADDR_W-1:0] mask);
		logic [ADDR_W-1:0] r;
		logic [CNT_W-1:0]  rank;
		r = '0;
		for (int p = 0; p < ADDR_W; p++) begin
			rank = popcount(mask & ((ADDR_W'(1) << p) - ADDR_W'(1)));
			r[p] = mask[p] & code[rank];
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/tiam_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tiam_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/tiam_key_cmp.sv
// Shared compare unit: equality of two table entries under the output mask.
`timescale 1ns / 1ps

module tiam_key_cmp
	import tiam_pkg::*;
(
	input  entry_t           a,
	input  entry_t           b,
	input  logic [VAL_W-1:0] omask,
	output logic             eq
);

	// Unloaded entries match each other and nothing loaded.
	assign eq = (a.written == b.written) &&
		(!a.written || (((a.value ^ b.value) & omask) == '0));

endmodule

FILE: hw/rtl/truth_table_ignore_mask_analysis.sv
// Top level: stream ports, configuration, table memories and analyse sequencer.
//
//   Channel   Direction  Beat contents
//   s_*       in         tdata: entry_index[11:0], entry_value[21:12]; tuser: req_type
//   m_*       out        tdata: packed_word[21:0], table_incomplete[22],
//                               first_unset_index[34:23]
//   cfg_*     in         cfg_addr selects num_inputs (0) or num_outputs (1)
//
// A load is answered straight from the idle state; a read first passes S_RD for the
// registered memory read. An analyse clears the visited map and scans the written map
// over all N states, then tests the visited bit of each state; for each unvisited state
// it compares the n single-flip neighbours, checks every non-empty subset of the c
// single-flip candidates and marks each state of the widest valid class, where N = 2^n.
// After reset a clearing pass over all 4096 entries empties the written map; no beat
// is taken meanwhile. One request is in work at a time; s_tready is low until its
// result is in the output register, and while that register holds an untaken result.
`timescale 1ns / 1ps

module truth_table_ignore_mask_analysis
	import tiam_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // entry_index[11:0], entry_value[21:12]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // packed_word[21:0], table_incomplete[22], first[34:23]
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [3:0]  cfg_wdata
);

	localparam logic [ADDR_W-1:0] ALL_ONES = '1;

	state_t st_q, st_d;

	logic [3:0] num_inputs_q, num_outputs_q;
	logic [3:0] n_eff, no_eff;
	logic [VAL_W-1:0]  omask;
	logic [ADDR_W-1:0] last_idx;

	logic [ADDR_W-1:0] clr_q;
	logic              m_tvalid_q;
	result_t           res_q, out_d;
	logic              out_set;

	logic [ADDR_W-1:0] idx_q, first_q, cand_q, mask_q, best_code_q, cntm1_q;
	logic [ADDR_W:0]   j_q, limit_q;
	logic [ADDR_W-1:0] k_q;
	logic              found_q, bad_q;
	logic [CNT_W-1:0]  bit_q, c_q, best_n_q;
	entry_t            base_q;

	logic [1:0]        in_req;
	logic [ADDR_W-1:0] in_idx;
	logic [VAL_W-1:0]  in_val;
	logic              in_range;
	logic [ADDR_W-1:0] onehot, j_clr, mark_addr;
	logic              eq, last_i;

	logic              tab_we, ign_we, vis_we, bad_we;
	logic [ADDR_W-1:0] tab_waddr, tab_raddr, ign_waddr, ign_raddr;
	logic [ADDR_W-1:0] vis_waddr, vis_raddr, bad_waddr, bad_raddr;
	entry_t            tab_wdata, tab_rdata;
	logic [ADDR_W-1:0] ign_wdata, ign_rdata;
	logic              vis_wdata, vis_rdata, bad_wdata, bad_rdata;
	logic [PACK_W-1:0] packed_word;

	// Out-of-range register values are clamped.
	always_comb begin
		if (num_inputs_q < 4'd1) begin
			n_eff = 4'd1;
		end else if (num_inputs_q > 4'(MAX_INPUTS)) begin
			n_eff = 4'(MAX_INPUTS);
		end else begin
			n_eff = num_inputs_q;
		end
		if (num_outputs_q < 4'd1) begin
			no_eff = 4'd1;
		end else if (num_outputs_q > 4'(MAX_OUTPUTS)) begin
			no_eff = 4'(MAX_OUTPUTS);
		end else begin
			no_eff = num_outputs_q;
		end
	end

	assign omask    = VAL_W'((11'd1 << no_eff) - 11'd1);
	assign last_idx = ADDR_W'((13'd1 << n_eff) - 13'd1);

	assign in_req   = s_tuser;
	assign in_idx   = s_tdata[11:0];
	assign in_val   = s_tdata[21:12];
	assign in_range = (in_idx & ~last_idx) == '0;

	assign onehot    = ADDR_W'(1) << bit_q;
	assign j_clr     = j_q[ADDR_W-1:0] & ~onehot;
	assign mark_addr = (idx_q & ~mask_q) | deposit(k_q, mask_q);
	assign last_i    = idx_q == last_idx;

	assign packed_word = PACK_W'(tab_rdata.value & omask) |
		(PACK_W'(ign_rdata & last_idx) << no_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_inputs_q  <= 4'd4;
			num_outputs_q <= 4'd1;
		end else if (cfg_we) begin
			if (cfg_addr == CFG_NUM_INPUTS) begin
				num_inputs_q <= cfg_wdata;
			end
			if (cfg_addr == CFG_NUM_OUTPUTS) begin
				num_outputs_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_INIT;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == S_INIT) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_set) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_set) begin
			res_q <= out_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		s_tready  = 1'b0;
		out_set   = 1'b0;
		out_d     = '0;
		tab_we    = 1'b0;
		tab_waddr = clr_q;
		tab_wdata = '0;
		tab_raddr = idx_q;
		ign_we    = 1'b0;
		ign_waddr = mark_addr;
		ign_wdata = mask_q;
		ign_raddr = in_idx;
		vis_we    = 1'b0;
		vis_waddr = idx_q;
		vis_wdata = 1'b0;
		vis_raddr = idx_q;
		bad_we    = 1'b0;
		bad_waddr = j_q[ADDR_W-1:0];
		bad_wdata = bad_q;
		bad_raddr = j_clr;
		unique case (st_q)
			S_INIT: begin
				tab_we = 1'b1;
				if (clr_q == ALL_ONES) begin
					st_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready  = !m_tvalid_q || m_tready;
				tab_raddr = in_idx;
				if (s_tready && s_tvalid) begin
					unique case (in_req)
						REQ_LOAD: begin
							tab_we    = in_range;
							tab_waddr = in_idx;
							tab_wdata = '{written: 1'b1, value: in_val & omask};
							out_set   = 1'b1;
						end
						REQ_ANALYZE: st_d = S_CLR_RD;
						REQ_READ: begin
							if (in_range) begin
								st_d = S_RD;
							end else begin
								out_set = 1'b1;
							end
						end
						default: out_set = 1'b1;
					endcase
				end
			end
			S_RD: begin
				out_set           = 1'b1;
				out_d.packed_word = packed_word;
				st_d              = S_IDLE;
			end
			S_CLR_RD: begin
				vis_we = 1'b1;
				st_d   = S_CLR_CHK;
			end
			S_CLR_CHK: st_d = last_i ? S_VIS_RD : S_CLR_RD;
			S_VIS_RD:  st_d = S_VIS_CHK;
			S_VIS_CHK: begin
				if (vis_rdata) begin
					st_d = last_i ? S_RD : S_VIS_RD;
				end else begin
					st_d = S_CAND_RD;
				end
				if (vis_rdata && last_i) begin
					// Walk finished: report and return.
					out_set                 = 1'b1;
					out_d.table_incomplete  = found_q;
					out_d.first_unset_index = first_q;
					st_d                    = S_IDLE;
				end
			end
			S_CAND_RD: begin
				tab_raddr = idx_q ^ onehot;
				st_d      = S_CAND_CHK;
			end
			S_CAND_CHK: st_d = (bit_q == n_eff - 4'd1) ? S_SUB_INIT : S_CAND_RD;
			S_SUB_INIT: st_d = S_SUB_RD;
			S_SUB_RD: begin
				if (j_q == limit_q) begin
					st_d = S_MARK;
				end else begin
					tab_raddr = idx_q ^ deposit(j_q[ADDR_W-1:0], cand_q);
					st_d      = S_SUB_CHK;
				end
			end
			S_SUB_CHK: st_d = eq ? S_BAD_RD : S_SUB_WR;
			S_BAD_RD: begin
				if (bit_q == c_q) begin
					st_d = S_SUB_WR;
				end else if (j_q[bit_q] && (j_clr != '0)) begin
					st_d = S_BAD_CHK;
				end
			end
			S_BAD_CHK: st_d = bad_rdata ? S_SUB_WR : S_BAD_RD;
			S_SUB_WR: begin
				bad_we = 1'b1;
				st_d   = S_SUB_RD;
			end
			S_MARK: begin
				ign_we    = 1'b1;
				vis_we    = 1'b1;
				vis_waddr = mark_addr;
				vis_wdata = 1'b1;
				if (k_q == cntm1_q) begin
					if (last_i) begin
						out_set                 = 1'b1;
						out_d.table_incomplete  = found_q;
						out_d.first_unset_index = first_q;
						st_d                    = S_IDLE;
					end else begin
						st_d = S_VIS_RD;
					end
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				idx_q   <= '0;
				found_q <= 1'b0;
				first_q <= '0;
			end
			S_CLR_CHK: begin
				if (!tab_rdata.written && !found_q) begin
					found_q <= 1'b1;
					first_q <= idx_q;
				end
				idx_q <= last_i ? '0 : idx_q + 1'b1;
			end
			S_VIS_CHK: begin
				if (vis_rdata) begin
					idx_q <= idx_q + 1'b1;
				end else begin
					base_q <= tab_rdata;
					bit_q  <= '0;
					cand_q <= '0;
				end
			end
			S_CAND_CHK: begin
				if (eq) begin
					cand_q <= cand_q | onehot;
				end
				bit_q <= bit_q + 1'b1;
			end
			S_SUB_INIT: begin
				c_q         <= popcount(cand_q);
				limit_q     <= (ADDR_W+1)'(1) << popcount(cand_q);
				j_q         <= (ADDR_W+1)'(1);
				best_n_q    <= '0;
				best_code_q <= '0;
			end
			S_SUB_RD: begin
				if (j_q == limit_q) begin
					mask_q  <= deposit(best_code_q, cand_q);
					cntm1_q <= ADDR_W'(((ADDR_W+1)'(1) << best_n_q) - (ADDR_W+1)'(1));
					k_q     <= '0;
				end
			end
			S_SUB_CHK: begin
				bad_q <= !eq;
				bit_q <= '0;
			end
			S_BAD_RD: begin
				if ((bit_q != c_q) && !(j_q[bit_q] && (j_clr != '0))) begin
					bit_q <= bit_q + 1'b1;
				end
			end
			S_BAD_CHK: begin
				if (bad_rdata) begin
					bad_q <= 1'b1;
				end else begin
					bit_q <= bit_q + 1'b1;
				end
			end
			S_SUB_WR: begin
				if (!bad_q && (popcount(j_q[ADDR_W-1:0]) > best_n_q)) begin
					best_n_q    <= popcount(j_q[ADDR_W-1:0]);
					best_code_q <= j_q[ADDR_W-1:0];
				end
				j_q <= j_q + 1'b1;
			end
			S_MARK: begin
				k_q <= k_q + 1'b1;
				if (k_q == cntm1_q) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	tiam_key_cmp u_cmp (
		.a     (base_q),
		.b     (tab_rdata),
		.omask (omask),
		.eq    (eq)
	);

	tiam_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_tab (
		.clk (clk), .we (tab_we), .waddr (tab_waddr), .wdata (tab_wdata),
		.raddr (tab_raddr), .rdata (tab_rdata)
	);

	tiam_ram #(.WIDTH(ADDR_W), .DEPTH(DEPTH)) u_ign (
		.clk (clk), .we (ign_we), .waddr (ign_waddr), .wdata (ign_wdata),
		.raddr (ign_raddr), .rdata (ign_rdata)
	);

	tiam_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vis (
		.clk (clk), .we (vis_we), .waddr (vis_waddr), .wdata (vis_wdata),
		.raddr (vis_raddr), .rdata (vis_rdata)
	);

	tiam_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_bad (
		.clk (clk), .we (bad_we), .waddr (bad_waddr), .wdata (bad_wdata),
		.raddr (bad_raddr), .rdata (bad_rdata)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, res_q};

endmodule

FILE: tb/truth_table_ignore_mask_analysis_checker.sv
// Checker: watches the request, result and configuration ports, predicts each result and compares.
`timescale 1ns / 1ps

module truth_table_ignore_mask_analysis_checker
	import tiam_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [3:0]  cfg_wdata,
	output int          fail_count,
	output int          results_due
);

	logic [3:0]        inputs_reg;
	logic [3:0]        outputs_reg;
	logic [VAL_W-1:0]  out_word [DEPTH];
	logic              loaded   [DEPTH];
	logic [ADDR_W-1:0] ign_mask [DEPTH];
	logic              seen     [DEPTH];
	logic              subset_bad [DEPTH];
	result_t           due_q [$];

	function automatic int eff_n();
		if (inputs_reg < 1) return 1;
		if (inputs_reg > MAX_INPUTS) return MAX_INPUTS;
		return inputs_reg;
	endfunction

	function automatic int eff_o();
		if (outputs_reg < 1) return 1;
		if (outputs_reg > MAX_OUTPUTS) return MAX_OUTPUTS;
		return outputs_reg;
	endfunction

	// Unloaded entries share a key that no loaded word can take.
	function automatic int word_key(int s);
		int a;
		a = s & (DEPTH - 1);
		if (!loaded[a]) return 'h10000;
		return int'(out_word[a]) & ((1 << eff_o()) - 1);
	endfunction

	// Scatters the low bits of code over the set bits of sel, lowest first.
	function automatic int spread(int code, int sel);
		int r;
		int k;
		r = 0;
		k = 0;
		for (int p = 0; p < ADDR_W; p++) begin
			if (sel[p]) begin
				if (code[k]) r |= 1 << p;
				k++;
			end
		end
		return r;
	endfunction

	function automatic int widest_mask(int s, int n);
		int base;
		int cand;
		int c;
		int best;
		int best_n;
		logic bad;
		base = word_key(s);
		cand = 0;
		for (int b = 0; b < n; b++)
			if (word_key(s ^ (1 << b)) == base) cand |= 1 << b;
		c = $countones(cand);
		subset_bad[0] = 1'b0;
		for (int j = 1; j < (1 << c); j++) begin
			bad = word_key(s ^ spread(j, cand)) != base;
			for (int b = 0; b < c && !bad; b++)
				if (j[b]) bad = subset_bad[j & ~(1 << b)];
			subset_bad[j] = bad;
		end
		best = 0;
		best_n = 0;
		for (int j = 1; j < (1 << c); j++)
			if (!subset_bad[j] && $countones(j) > best_n) begin
				best_n = $countones(j);
				best = j;
			end
		return spread(best, cand);
	endfunction

	function automatic result_t run_analysis();
		result_t r;
		int size;
		int m;
		int t;
		size = 1 << eff_n();
		r = '0;
		for (int i = 0; i < DEPTH; i++) seen[i] = 1'b0;
		for (int i = 0; i < size; i++) begin
			if (!seen[i]) begin
				m = widest_mask(i, eff_n());
				for (int k = 0; k < (1 << $countones(m)); k++) begin
					t = ((i & ~m) | spread(k, m)) & (DEPTH - 1);
					ign_mask[t] = ADDR_W'(m);
					seen[t] = 1'b1;
				end
			end
		end
		for (int i = 0; i < size; i++)
			if (!loaded[i]) begin
				r.table_incomplete = 1'b1;
				r.first_unset_index = ADDR_W'(i);
				break;
			end
		return r;
	endfunction

	function automatic result_t predict_beat(logic [1:0] req, int idx, int val);
		result_t r;
		int size;
		int o;
		longint w;
		size = 1 << eff_n();
		o = eff_o();
		r = '0;
		if (req == REQ_LOAD) begin
			if (idx < size) begin
				out_word[idx] = VAL_W'(val & ((1 << o) - 1));
				loaded[idx] = 1'b1;
			end
		end else if (req == REQ_ANALYZE) begin
			r = run_analysis();
		end else if (req == REQ_READ) begin
			if (idx < size) begin
				w = (longint'(out_word[idx]) & ((1 << o) - 1))
					| ((longint'(ign_mask[idx]) & (size - 1)) << o);
				r.packed_word = PACK_W'(w);
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		int errs;
		errs = 0;
		if (!arst_n) begin
			inputs_reg <= 4'd4;
			outputs_reg <= 4'd1;
			for (int i = 0; i < DEPTH; i++) loaded[i] = 1'b0;
			due_q.delete();
			fail_count <= 0;
			results_due <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == CFG_NUM_INPUTS) inputs_reg <= cfg_wdata;
				else outputs_reg <= cfg_wdata;
			end
			if (s_tvalid && s_tready)
				due_q.insert(due_q.size(), predict_beat(s_tuser, int'(s_tdata[11:0]),
					int'(s_tdata[21:12])));
			if (m_tvalid && m_tready) begin
				got = m_tdata[34:0];
				if (due_q.size() == 0) begin
					$error("result beat with nothing expected: %h", got);
					errs++;
				end else begin
					want = due_q.pop_front();
					if (got.packed_word !== want.packed_word) begin
						$error("packed_word expected %h got %h", want.packed_word,
							got.packed_word);
						errs++;
					end
					if (got.table_incomplete !== want.table_incomplete) begin
						$error("table_incomplete expected %b got %b",
							want.table_incomplete, got.table_incomplete);
						errs++;
					end
					if (got.first_unset_index !== want.first_unset_index) begin
						$error("first_unset_index expected %0d got %0d",
							want.first_unset_index, got.first_unset_index);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			results_due <= due_q.size();
		end
	end

endmodule

FILE: tb/truth_table_ignore_mask_analysis_tb.sv
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module truth_table_ignore_mask_analysis_tb;
	import tiam_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int IDLE_LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_addr = CFG_NUM_INPUTS;
	logic [3:0]  cfg_wdata = '0;
	int          fail_count;
	int          results_due;

	bit quiet = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int beats_sent = 0;
	int size_now = 16;
	bit was_loaded [DEPTH];
	bit has_mask   [DEPTH];

	truth_table_ignore_mask_analysis DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	truth_table_ignore_mask_analysis_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .results_due(results_due)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Result side: random stall bursts, plus one long hold-off when asked for.
	always @(posedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served = hold_asked;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			hold_left = $urandom_range(1, 9) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("truth_table_ignore_mask_analysis: mismatch");
			$finish;
		end
	end

	task automatic send_beat(logic [1:0] req, int idx, int val);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {2'b00, 10'(val), 12'(idx)};
		do @(posedge clk); while (!s_tready);
		if (req == REQ_LOAD && idx < size_now) begin
			was_loaded[idx] = 1;
			beats_sent++;
		end else if (req == REQ_ANALYZE) begin
			for (int i = 0; i < size_now; i++) has_mask[i] = 1;
			beats_sent++;
		end else if (req == REQ_READ) begin
			beats_sent++;
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] addr, int val);
		drain();
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= 4'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == CFG_NUM_INPUTS)
			size_now = 1 << ((val < 1) ? 1 : (val > MAX_INPUTS) ? MAX_INPUTS : val);
	endtask

	// A read goes to an entry holding a loaded word and a mask if one is found, else out of range.
	task automatic read_some();
		int idx;
		for (int t = 0; t < 8; t++) begin
			idx = $urandom_range(0, size_now - 1);
			if (was_loaded[idx] && has_mask[idx]) begin
				send_beat(REQ_READ, idx, $urandom_range(0, 1023));
				return;
			end
		end
		if (size_now < DEPTH)
			send_beat(REQ_READ, $urandom_range(size_now, DEPTH - 1), $urandom_range(0, 1023));
	endtask

	task automatic mixed_ops(int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 9) read_some();
			else if (pick < 14) send_beat(REQ_LOAD, $urandom_range(0, size_now - 1),
				$urandom_range(0, 1023));
			else if (pick < 16) send_beat(REQ_LOAD, $urandom_range(0, DEPTH - 1),
				$urandom_range(0, 1023));
			else if (pick < 17) send_beat(REQ_UNKNOWN, $urandom_range(0, DEPTH - 1),
				$urandom_range(0, 1023));
			else if (pick < 18) send_beat(REQ_ANALYZE, 0, 0);
			else if (size_now < DEPTH) send_beat(REQ_READ,
				$urandom_range(size_now, DEPTH - 1), $urandom_range(0, 1023));
			else read_some();
		end
	endtask

	// Words depend on the index bits in dep only, bar an occasional random word, so that ignore classes form.
	task automatic fill_table(int skip_pct);
		int dep;
		int salt;
		int val;
		dep = $urandom_range(0, size_now - 1);
		salt = $urandom_range(0, 1023);
		for (int i = 0; i < size_now; i++) begin
			if ($urandom_range(0, 99) < skip_pct) continue;
			val = (((i & dep) * 13) ^ salt) & 'h3ff;
			if ($urandom_range(0, 7) == 0) val = $urandom_range(0, 1023);
			send_beat(REQ_LOAD, i, val);
		end
	endtask

	initial begin
		int val;
		for (int i = 0; i < DEPTH; i++) begin
			was_loaded[i] = 0;
			has_mask[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings of four inputs and one output.
		for (int i = 0; i < 16; i++) send_beat(REQ_LOAD, i, (i >> 2) & 1);
		send_beat(REQ_LOAD, 3, 'h3ff);
		send_beat(REQ_LOAD, 3, 0);
		send_beat(REQ_LOAD, 4095, 'h3ff);
		send_beat(REQ_UNKNOWN, 'hfff, 'h3ff);
		send_beat(REQ_ANALYZE, 0, 0);
		send_beat(REQ_READ, 0, 0);
		send_beat(REQ_READ, 15, 0);
		send_beat(REQ_READ, 4095, 0);
		send_beat(REQ_READ, 2048, 'h3ff);

		// All inputs and all outputs through out-of-range writes. Only the lowest
		// sixteen entries are loaded, so each higher input bit opens a wide class.
		write_reg(CFG_NUM_INPUTS, 15);
		write_reg(CFG_NUM_OUTPUTS, 15);
		val = $urandom_range(0, 1023);
		for (int i = 0; i < 16; i++) send_beat(REQ_LOAD, i, val);
		send_beat(REQ_ANALYZE, 0, 0);
		for (int i = 0; i < 20; i++) read_some();
		send_beat(REQ_READ, 15, 0);

		write_reg(CFG_NUM_INPUTS, 0);
		write_reg(CFG_NUM_OUTPUTS, 0);
		send_beat(REQ_LOAD, 1, 'h3ff);
		send_beat(REQ_ANALYZE, 0, 0);
		mixed_ops(10);

		while (beats_sent < 1650) begin
			write_reg(CFG_NUM_INPUTS, $urandom_range(0, 7));
			write_reg(CFG_NUM_OUTPUTS, $urandom_range(0, 15));
			fill_table($urandom_range(0, 3) == 0 ? 15 : 0);
			send_beat(REQ_ANALYZE, 0, 0);
			if (hold_asked == 0 || $urandom_range(0, 3) == 0) begin
				hold_asked++;
				for (int i = 0; i < 40; i++) send_beat(REQ_LOAD,
					$urandom_range(0, size_now - 1), $urandom_range(0, 1023));
			end
			mixed_ops(30);
			if ($urandom_range(0, 3) == 0) drain();
			send_beat(REQ_ANALYZE, 0, 0);
			mixed_ops(30);
		end

		quiet = 1;
		write_reg(CFG_NUM_INPUTS, 6);
		write_reg(CFG_NUM_OUTPUTS, 10);
		fill_table(0);
		send_beat(REQ_ANALYZE, 0, 0);
		mixed_ops(40);

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("truth_table_ignore_mask_analysis: match");
		end else begin
			$display("truth_table_ignore_mask_analysis: mismatch");
		end
		$finish;
	end

endmodule
